[hdl/tts_pkg.sv]
// Shared definitions for the transition table sampler: field widths,
// request codes and default sizes. No dependencies.
`default_nettype none

package tts_pkg;

   // Default sizes of the probability table.
   localparam int MAX_STATES_DEF     = 16;
   localparam int MAX_ACTIONS_DEF    = 4;
   localparam int PROB_FRAC_BITS_DEF = 16;

   // Fixed field widths of the channels.
   localparam int REQ_TYPE_W = 2;
   localparam int STATE_W    = 4;
   localparam int ACT_W      = 2;
   localparam int PROB_W     = 17;
   localparam int RAND_W     = 16;
   localparam int NSTATES_W  = 5;

   // Reset value of the num_states register.
   localparam logic [NSTATES_W-1:0] NSTATES_RESET = 5'd16;

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SET    = 2'd0,
      REQ_GET    = 2'd1,
      REQ_SAMPLE = 2'd2
   } req_code_type;

endpackage

`default_nettype wire

[hdl/tts_if.sv]
// Channel interfaces of the transition table sampler: request, response
// and register write. Depends on tts_pkg.
`default_nettype none

interface tts_req_if;
   import tts_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [STATE_W-1:0]    cur_state;
   logic [ACT_W-1:0]      act;
   logic [STATE_W-1:0]    target_state;
   logic [PROB_W-1:0]     prob_in;
   logic [RAND_W-1:0]     random_value;

   modport source (output valid, req_type, cur_state, act, target_state, prob_in,
                   random_value, input ready);
   modport sink   (input valid, req_type, cur_state, act, target_state, prob_in,
                   random_value, output ready);
endinterface

interface tts_rsp_if;
   import tts_pkg::*;

   logic               valid;
   logic               ready;
   logic [PROB_W-1:0]  prob_out;
   logic [STATE_W-1:0] sampled_state;
   logic               miss;

   modport source (output valid, prob_out, sampled_state, miss, input ready);
   modport sink   (input valid, prob_out, sampled_state, miss, output ready);
endinterface

interface tts_csr_if;
   import tts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [NSTATES_W-1:0] num_states;

   modport source (output valid, num_states, input ready);
   modport sink   (input valid, num_states, output ready);
endinterface

`default_nettype wire

[hdl/transition_table_sampler_top.sv]
// Transition table sampler top level: probability table in one synchronous
// memory with set, get and sample requests. Depends on tts_pkg and tts_if.
//
// Use:
// - req_bus carries one request a beat: set writes one entry (saturated to
//   one), get reads one entry, sample draws a next state by walking the
//   row of (cur_state, act) and summing probabilities until the running
//   sum reaches the random draw. Request code 3 is dropped.
// - rsp_bus returns one beat for each get and sample, none for a set.
// - csr_bus writes num_states at any time; it is always ready.
// Timing:
// - A set writes its entry at the request beat. A get reads its entry
//   through the registered read port, then loads it into the output
//   register. A sample walks the row in order, one entry per cycle from
//   the single read port, and visits at most num_states entries (capped
//   at MAX_STATES).
// - The response sits in an output register; a new request is taken while
//   it waits. When the receiver stalls, the next get or sample holds its
//   finished result until the output register frees up.
// Reset: a clearing pass writes zero to every entry, one per cycle, for
// all MAX_STATES*MAX_ACTIONS*MAX_STATES entries (1024 by default);
// requests are not taken during it.
`default_nettype none

module transition_table_sampler_top #(
   parameter int MAX_STATES     = tts_pkg::MAX_STATES_DEF,
   parameter int MAX_ACTIONS    = tts_pkg::MAX_ACTIONS_DEF,
   parameter int PROB_FRAC_BITS = tts_pkg::PROB_FRAC_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   tts_req_if.sink    req_bus,
   tts_rsp_if.source  rsp_bus,
   tts_csr_if.sink    csr_bus
);
   import tts_pkg::*;

   localparam int EW      = PROB_FRAC_BITS + 1;
   localparam int DEPTH   = MAX_STATES * MAX_ACTIONS * MAX_STATES;
   localparam int AW      = $clog2(DEPTH);
   localparam int POS_W   = NSTATES_W;
   localparam int LIM_CAP = (MAX_STATES < 31) ? MAX_STATES : 31;
   localparam int SUM_W   = PROB_FRAC_BITS + 6;
   localparam int CMP_W   = SUM_W + RAND_W;
   localparam int SAT_W   = (EW > PROB_W) ? EW : PROB_W;
   localparam logic [EW-1:0] PROB_ONE = EW'(1) << PROB_FRAC_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_GET   = 4'b0100,
      ST_WALK  = 4'b1000
   } state_type;

   // Control registers.
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [NSTATES_W-1:0] num_states_ff, num_states_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [PROB_W-1:0]    rsp_prob_ff, rsp_prob_in;
   logic [STATE_W-1:0]   rsp_state_ff, rsp_state_in;
   logic                 rsp_miss_ff, rsp_miss_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [POS_W-1:0]     limit_ff, limit_in;
   logic [RAND_W-1:0]    draw_ff, draw_in;
   logic [AW-1:0]        row_base_ff, row_base_in;
   logic                 row_ok_ff, row_ok_in;

   // Memory ports.
   logic [EW-1:0]        prob_mem [DEPTH];
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data_ff;

   // Request decode.
   logic                 req_beat;
   logic                 s_ok, a_ok, n_ok;
   logic [AW-1:0]        req_base;
   logic [EW-1:0]        set_value;
   logic [POS_W-1:0]     req_limit;

   // Walk datapath.
   logic [EW-1:0]        entry;
   logic [SUM_W-1:0]     new_sum;
   logic                 reached;
   logic                 hit;
   logic                 last;
   logic                 finish;
   logic                 slot_free;

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.prob_out      = rsp_prob_ff;
   assign rsp_bus.sampled_state = rsp_state_ff;
   assign rsp_bus.miss          = rsp_miss_ff;

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // Index checks and row base address of the request.
   assign s_ok     = (32'(req_bus.cur_state) < MAX_STATES);
   assign a_ok     = (32'(req_bus.act) < MAX_ACTIONS);
   assign n_ok     = (32'(req_bus.target_state) < MAX_STATES);
   assign req_base = AW'((AW'(req_bus.cur_state) * AW'(MAX_ACTIONS) + AW'(req_bus.act))
                         * AW'(MAX_STATES));

   // Saturate the stored probability at one.
   assign set_value = (SAT_W'(req_bus.prob_in) > SAT_W'(PROB_ONE)) ?
                      PROB_ONE : EW'(req_bus.prob_in);

   // Walk length: num_states capped at the table row length.
   assign req_limit = (32'(num_states_ff) > LIM_CAP) ? POS_W'(LIM_CAP) : num_states_ff;

   // Running sum and exact compare of draw against it on a common scale.
   assign entry   = row_ok_ff ? rd_data_ff : '0;
   assign new_sum = sum_ff + SUM_W'(entry);
   assign reached = ((CMP_W'(draw_ff) << PROB_FRAC_BITS) <= (CMP_W'(new_sum) << RAND_W));
   assign hit     = (limit_ff != '0) && reached;
   assign last    = ((pos_ff + POS_W'(1)) == limit_ff);
   assign finish  = (limit_ff == '0) || hit || last;

   // Next-state logic for control, walk and memory ports.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      num_states_in = num_states_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_prob_in   = rsp_prob_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_miss_in   = rsp_miss_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      limit_in      = limit_ff;
      draw_in       = draw_ff;
      row_base_in   = row_base_ff;
      row_ok_in     = row_ok_ff;
      wr_en         = 1'b0;
      wr_addr       = req_base + AW'(req_bus.target_state);
      wr_data       = set_value;
      rd_en         = 1'b0;
      rd_addr       = req_base + AW'(req_bus.target_state);

      if (csr_bus.valid) begin
         num_states_in = csr_bus.num_states;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               case (req_bus.req_type)
                  REQ_SET: begin
                     wr_en = s_ok && a_ok && n_ok;
                  end
                  REQ_GET: begin
                     rd_en     = s_ok && a_ok && n_ok;
                     row_ok_in = s_ok && a_ok && n_ok;
                     state_in  = ST_GET;
                  end
                  REQ_SAMPLE: begin
                     rd_en       = s_ok && a_ok;
                     rd_addr     = req_base;
                     row_ok_in   = s_ok && a_ok;
                     row_base_in = req_base;
                     limit_in    = req_limit;
                     draw_in     = req_bus.random_value;
                     pos_in      = '0;
                     sum_in      = '0;
                     state_in    = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GET: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prob_in  = PROB_W'(entry);
               rsp_state_in = '0;
               rsp_miss_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            rd_addr = row_base_ff + AW'(pos_ff + POS_W'(1));
            if (finish) begin
               // Hold the finished walk until the output register is free.
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_prob_in  = '0;
                  rsp_state_in = hit ? STATE_W'(pos_ff) : '0;
                  rsp_miss_in  = !hit;
                  state_in     = ST_IDLE;
               end
            end else begin
               rd_en  = row_ok_ff;
               pos_in = pos_ff + POS_W'(1);
               sum_in = new_sum;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         num_states_ff <= NSTATES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         num_states_ff <= num_states_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_prob_ff  <= rsp_prob_in;
      rsp_state_ff <= rsp_state_in;
      rsp_miss_ff  <= rsp_miss_in;
      pos_ff       <= pos_in;
      sum_ff       <= sum_in;
      limit_ff     <= limit_in;
      draw_ff      <= draw_in;
      row_base_ff  <= row_base_in;
      row_ok_ff    <= row_ok_in;
   end

   // Probability table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prob_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= prob_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sim/transition_table_sampler_top_tb.sv]
// Self-checking testbench for transition_table_sampler_top: drives set, get and sample
// requests, mirrors the probability table and compares every response beat.
// Depends on tts_pkg, the tts_if channel interfaces and the top level RTL.
`default_nettype none

module transition_table_sampler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tts_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [PROB_W-1:0] PROB_ONE = 17'd1 << PROB_FRAC_BITS_DEF;
   localparam int TABLE_DEPTH = MAX_STATES_DEF * MAX_ACTIONS_DEF * MAX_STATES_DEF;
   // Longest sample walk plus request and output register, with margin.
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [PROB_W-1:0]  prob;
      logic [STATE_W-1:0] state;
      logic               miss;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset;

   tts_req_if req_ch ();
   tts_rsp_if rsp_ch ();
   tts_csr_if csr_ch ();

   transition_table_sampler_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   // Mirror of the probability table and the walk length register.
   logic [PROB_W-1:0]    prob_mem [TABLE_DEPTH];
   logic [NSTATES_W-1:0] walk_len = NSTATES_RESET;
   rsp_beat_type         pending_rsp [$];

   int  err_count = 0;
   int  n_set = 0, n_get = 0, n_sample = 0, n_miss = 0, n_checked = 0, n_cfg = 0;
   int  quiet_cycles = 0;
   int  hold_rsp_len = 0;
   bit  send_gaps = 1'b1;
   bit  recv_gaps = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the table mirror for one accepted request and queue its response.
   function automatic void mirror_request(input logic [REQ_TYPE_W-1:0] kind,
                                          input logic [STATE_W-1:0] cur,
                                          input logic [ACT_W-1:0] act,
                                          input logic [STATE_W-1:0] nxt,
                                          input logic [PROB_W-1:0] prob,
                                          input logic [RAND_W-1:0] rnd);
      rsp_beat_type res;
      int unsigned  acc;
      int unsigned  walk;
      bit           found;
      logic [9:0]   slot;
      slot = {cur, act, nxt};
      res = '{prob: '0, state: '0, miss: 1'b0};
      case (kind)
         REQ_SET: begin
            prob_mem[slot] = (prob > PROB_ONE) ? PROB_ONE : prob;
            n_set++;
         end
         REQ_GET: begin
            res.prob = prob_mem[slot];
            pending_rsp.push_back(res);
            n_get++;
         end
         REQ_SAMPLE: begin
            // Draw and running sum share the same 16 fraction bits.
            walk = (32'(walk_len) > MAX_STATES_DEF) ? MAX_STATES_DEF : 32'(walk_len);
            acc = 0;
            found = 1'b0;
            for (int i = 0; i < walk; i++) begin
               if (!found) begin
                  acc += 32'(prob_mem[{cur, act, i[3:0]}]);
                  if (32'(rnd) <= acc) begin
                     res.state = i[3:0];
                     found = 1'b1;
                  end
               end
            end
            res.miss = !found;
            if (!found) n_miss++;
            pending_rsp.push_back(res);
            n_sample++;
         end
         default: ;  // Unused code: dropped, no response.
      endcase
   endfunction

   // Offer one request beat after a random gap and wait until it is taken.
   task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [STATE_W-1:0] cur,
                           input logic [ACT_W-1:0] act, input logic [STATE_W-1:0] nxt,
                           input logic [PROB_W-1:0] prob, input logic [RAND_W-1:0] rnd);
      int gap;
      gap = send_gaps ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.cur_state    <= cur;
      req_ch.act          <= act;
      req_ch.target_state <= nxt;
      req_ch.prob_in      <= prob;
      req_ch.random_value <= rnd;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      mirror_request(kind, cur, act, nxt, prob, rnd);
   endtask

   // Stop offering, wait for every queued response, then let the block settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the num_states register; only called while the block is idle.
   task automatic write_walk_len(input logic [NSTATES_W-1:0] value);
      csr_ch.num_states <= value;
      csr_ch.valid      <= 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      walk_len = value;
      n_cfg++;
   endtask

   function automatic logic [PROB_W-1:0] rand_prob();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PROB_ONE;
         2: return PROB_W'($urandom_range(32'd65537, 32'd131071));
         3: return PROB_W'($urandom_range(0, 32'd131071));
         default: return PROB_W'($urandom_range(0, 12000));
      endcase
   endfunction

   function automatic logic [RAND_W-1:0] rand_draw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'hFFFF;
         default: return RAND_W'($urandom_range(0, 32'd65535));
      endcase
   endfunction

   // Fresh table: reads come back zero, a zero draw picks index 0, others miss.
   task automatic test_after_reset();
      send_req(REQ_GET, 4'd0, 2'd0, 4'd0, '0, '0);
      send_req(REQ_GET, 4'd15, 2'd3, 4'd15, '0, '0);
      send_req(REQ_SAMPLE, 4'd0, 2'd0, 4'd0, '0, 16'd0);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'hFFFF);
      send_req(REQ_UNUSED, 4'd0, 2'd0, 4'd0, 17'd777, 16'd0);
      send_req(REQ_GET, 4'd0, 2'd0, 4'd0, '0, '0);
   endtask

   // Saturation, erase, smallest step and a walk that reaches the last index.
   task automatic test_set_get_extremes();
      send_req(REQ_SET, 4'd15, 2'd3, 4'd15, 17'h1FFFF, 16'hFFFF);
      send_req(REQ_GET, 4'd15, 2'd3, 4'd15, '0, '0);
      send_req(REQ_SET, 4'd15, 2'd3, 4'd0, 17'd1, '0);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'd1);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'd2);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'hFFFF);
      send_req(REQ_SET, 4'd0, 2'd0, 4'd0, PROB_ONE, '0);
      send_req(REQ_GET, 4'd0, 2'd0, 4'd0, '0, '0);
      send_req(REQ_SET, 4'd0, 2'd0, 4'd0, '0, '0);
      send_req(REQ_GET, 4'd0, 2'd0, 4'd0, '0, '0);
      send_req(REQ_SET, 4'd7, 2'd2, 4'd9, 17'd65537, '0);
      send_req(REQ_GET, 4'd7, 2'd2, 4'd9, '0, '0);
   endtask

   // Walk length register: empty walk, single entry, above the table size.
   task automatic test_walk_length();
      wait_idle();
      write_walk_len(5'd0);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'd0);
      wait_idle();
      write_walk_len(5'd1);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'd1);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'd2);
      wait_idle();
      write_walk_len(5'd31);
      send_req(REQ_SAMPLE, 4'd15, 2'd3, 4'd0, '0, 16'hFFFF);
      wait_idle();
      write_walk_len(NSTATES_RESET);
   endtask

   // Receiver holds off while the sender keeps offering, then a full drain.
   task automatic test_backpressure();
      wait_idle();
      send_gaps = 1'b0;
      hold_rsp_len = HOLD_OFF_CYCLES;
      for (int k = 0; k < 40; k++) begin
         send_req((k % 2) ? REQ_GET : REQ_SAMPLE, STATE_W'($urandom), ACT_W'($urandom),
                  STATE_W'($urandom), rand_prob(), rand_draw());
      end
      // Sender pauses here until every response is back.
      wait_idle();
      send_gaps = 1'b1;
   endtask

   // Random traffic in phases, each with its own walk length and an idling mix.
   task automatic test_random_traffic();
      logic [NSTATES_W-1:0] walk_settings [7];
      logic [STATE_W-1:0]   hot_cur [4];
      logic [ACT_W-1:0]     hot_act [4];
      logic [STATE_W-1:0]   c;
      logic [ACT_W-1:0]     a;
      logic [REQ_TYPE_W-1:0] kind;
      int                   sent;
      int                   row;
      int                   pick;
      walk_settings = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd0, 5'd17, 5'd12};
      for (int h = 0; h < 4; h++) begin
         hot_cur[h] = STATE_W'($urandom);
         hot_act[h] = ACT_W'($urandom);
      end
      for (int p = 0; p < 7; p++) begin
         wait_idle();
         write_walk_len(walk_settings[p]);
         send_gaps = (p % 4) < 2 ? (p % 2 == 0) : 1'b1;
         recv_gaps = (p % 4) != 2 && (p % 4) != 3 ? 1'b1 : (p % 2 == 1 ? 1'b0 : 1'b1);
         if (p % 4 == 3) send_gaps = 1'b0;
         sent = 0;
         while (sent < 215) begin
            row = $urandom_range(0, 3);
            c = hot_cur[row];
            a = hot_act[row];
            if ($urandom_range(0, 9) < 3) begin
               // Fill a whole row with a small distribution, then draw from it.
               for (int n = 0; n < 16; n++) begin
                  send_req(REQ_SET, c, a, n[3:0],
                           ($urandom_range(0, 7) == 0) ? '0 :
                           PROB_W'($urandom_range(0, 9000)),
                           RAND_W'($urandom));
               end
               repeat (4) send_req(REQ_SAMPLE, c, a, STATE_W'($urandom), PROB_W'($urandom),
                                   rand_draw());
               sent += 20;
            end else begin
               if ($urandom_range(0, 9) < 3) begin
                  c = STATE_W'($urandom);
                  a = ACT_W'($urandom);
               end
               pick = $urandom_range(0, 19);
               kind = (pick < 5) ? REQ_SET : (pick < 10) ? REQ_GET :
                      (pick < 19) ? REQ_SAMPLE : REQ_UNUSED;
               send_req(kind, c, a, STATE_W'($urandom), rand_prob(), rand_draw());
               if (kind != REQ_UNUSED) sent++;
            end
         end
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // Response receiver: random stalls, plus a long hold-off on request.
   initial begin
      int stall;
      forever begin
         if (hold_rsp_len != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_rsp_len) @(posedge clock);
            hold_rsp_len = 0;
         end else begin
            stall = recv_gaps ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clock); while (rsp_ch.valid !== 1'b1 && hold_rsp_len == 0);
         end
      end
   end

   // Compare each response beat with the oldest queued prediction.
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with none expected (prob_out %0d, state %0d, miss %0b)",
                     $time, rsp_ch.prob_out, rsp_ch.sampled_state, rsp_ch.miss);
            err_count++;
         end else begin
            exp_beat = pending_rsp.pop_front();
            n_checked++;
            if (rsp_ch.prob_out !== exp_beat.prob) begin
               $display("%0t: prob_out expected %0d, got %0d", $time, exp_beat.prob,
                        rsp_ch.prob_out);
               err_count++;
            end
            if (rsp_ch.sampled_state !== exp_beat.state) begin
               $display("%0t: sampled_state expected %0d, got %0d", $time, exp_beat.state,
                        rsp_ch.sampled_state);
               err_count++;
            end
            if (rsp_ch.miss !== exp_beat.miss) begin
               $display("%0t: miss expected %0b, got %0b", $time, exp_beat.miss, rsp_ch.miss);
               err_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles without any beat on any channel ends the run.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d responses outstanding", $time,
                     quiet_cycles, pending_rsp.size());
            $display("transition_table_sampler_top_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      foreach (prob_mem[i]) prob_mem[i] = '0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_SET;
      req_ch.cur_state    <= '0;
      req_ch.act          <= '0;
      req_ch.target_state <= '0;
      req_ch.prob_in      <= '0;
      req_ch.random_value <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.num_states   <= NSTATES_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_set_get_extremes();
      test_walk_length();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      $display("Run covered %0d sets, %0d gets and %0d samples (%0d of them misses).",
               n_set, n_get, n_sample, n_miss);
      $display("Checked %0d response beats across %0d num_states writes.", n_checked, n_cfg);
      if (err_count == 0 && pending_rsp.size() == 0)
         $display("transition_table_sampler_top_tb: done, clean");
      else
         $display("transition_table_sampler_top_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
